@@ design/mrks_pkg.sv @@
`default_nettype none
package mrks_pkg;

  // Widths of the fields and registers
  localparam int unsigned SpeedW = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [SpeedW-1:0] SpeedMaxRst   = 8'd200;
  localparam logic [SpeedW-1:0] SpeedMinRst   = 8'd60;
  localparam logic [SpeedW-1:0] AccelStepRst  = 8'd1;
  localparam logic [SpeedW-1:0] DecelStepRst  = 8'd1;
  localparam logic [TimeW-1:0]  RunTimeRst    = 16'd1000;
  localparam logic [TimeW-1:0]  KickDelayRst  = 16'd2000;
  localparam logic [TimeW-1:0]  SolHoldRst    = 16'd10000;

  localparam logic [TimeW-1:0]  TimeMax       = {TimeW{1'b1}};

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PWM_CEIL   = 3'd0,
    CFG_PWM_FLOOR  = 3'd1,
    CFG_ACCEL_STEP = 3'd2,
    CFG_DECEL_STEP = 3'd3,
    CFG_RUN_TIME   = 3'd4,
    CFG_KICK_DELAY = 3'd5,
    CFG_SOL_HOLD   = 3'd6
  } cfg_idx_e;

  // Mission phases
  typedef enum logic [PhaseW-1:0] {
    PH_IDLE    = 3'd0,
    PH_BARK    = 3'd1,
    PH_RUN     = 3'd2,
    PH_DECEL   = 3'd3,
    PH_SEARCH  = 3'd4,
    PH_STOPPED = 3'd5,
    PH_KICK    = 3'd6,
    PH_END     = 3'd7
  } phase_e;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [SpeedW-1:0] pwm_ceil;
    logic [SpeedW-1:0] pwm_floor;
    logic [SpeedW-1:0] accel_step;
    logic [SpeedW-1:0] decel_step;
    logic [TimeW-1:0]  run_time_ms;
    logic [TimeW-1:0]  kick_delay_ms;
    logic [TimeW-1:0]  solenoid_hold_ms;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic [SpeedW-1:0] motor_speed;
    logic              brake_on;
    logic              solenoid_on;
    logic              wake_pulse;
    phase_e            phase;
  } result_t;

endpackage
`default_nettype wire

@@ design/motor_ramp_kick_sequencer_top.sv @@
`default_nettype none
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// input     | in_valid_i / in_ready_o    | start_pressed_i, line_seen_i, ms_tick_i
// result    | out_valid_o / out_ready_i  | motor_speed_o, brake_on_o, solenoid_on_o,
//           |                            | wake_pulse_o, phase_o
// config    | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One transaction per cycle unless the result register stalls: the whole sequencer
// update is combinational logic between the state registers and the result register.
// A result appears on the result channel the cycle after its input is accepted.
// in_ready_o drops only while the result register is full and not being taken.
// Reset returns to idle, clears PWM, timer and core outputs, loads default registers.
module motor_ramp_kick_sequencer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           start_pressed_i,
  input  wire logic                           line_seen_i,
  input  wire logic                           ms_tick_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mrks_pkg::SpeedW-1:0]         motor_speed_o,
  output logic                                brake_on_o,
  output logic                                solenoid_on_o,
  output logic                                wake_pulse_o,
  output logic [mrks_pkg::PhaseW-1:0]         phase_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mrks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mrks_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mrks_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  // Configuration registers
  mrks_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencer state and update logic
  mrks_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .start_pressed_i (start_pressed_i),
    .line_seen_i     (line_seen_i),
    .ms_tick_i       (ms_tick_i),
    .cfg_i           (cfg),
    .result_o        (core_res)
  );

  // Result register
  mrks_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .result_i    (core_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign motor_speed_o = out_res.motor_speed;
  assign brake_on_o    = out_res.brake_on;
  assign solenoid_on_o = out_res.solenoid_on;
  assign wake_pulse_o  = out_res.wake_pulse;
  assign phase_o       = out_res.phase;

endmodule
`default_nettype wire

@@ design/mrks_cfg_regs.sv @@
`default_nettype none
module mrks_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mrks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mrks_pkg::CfgDataW-1:0]  cfg_data_i,
  output mrks_pkg::cfg_t                      cfg_o
);
  import mrks_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; ignore indexes past the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_ceil         <= SpeedMaxRst;
      cfg_q.pwm_floor        <= SpeedMinRst;
      cfg_q.accel_step       <= AccelStepRst;
      cfg_q.decel_step       <= DecelStepRst;
      cfg_q.run_time_ms      <= RunTimeRst;
      cfg_q.kick_delay_ms    <= KickDelayRst;
      cfg_q.solenoid_hold_ms <= SolHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_CEIL:   cfg_q.pwm_ceil         <= cfg_data_i[SpeedW-1:0];
        CFG_PWM_FLOOR:  cfg_q.pwm_floor        <= cfg_data_i[SpeedW-1:0];
        CFG_ACCEL_STEP: cfg_q.accel_step       <= cfg_data_i[SpeedW-1:0];
        CFG_DECEL_STEP: cfg_q.decel_step       <= cfg_data_i[SpeedW-1:0];
        CFG_RUN_TIME:   cfg_q.run_time_ms      <= cfg_data_i[TimeW-1:0];
        CFG_KICK_DELAY: cfg_q.kick_delay_ms    <= cfg_data_i[TimeW-1:0];
        CFG_SOL_HOLD:   cfg_q.solenoid_hold_ms <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/mrks_core.sv @@
`default_nettype none
module mrks_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic           start_pressed_i,
  input  wire logic           line_seen_i,
  input  wire logic           ms_tick_i,
  input  wire mrks_pkg::cfg_t cfg_i,
  output mrks_pkg::result_t   result_o
);
  import mrks_pkg::*;

  phase_e              phase_q, phase_d;
  logic [SpeedW-1:0]   pwm_q, pwm_d;
  logic [TimeW-1:0]    elapsed_q, elapsed_d;
  logic [SpeedW-1:0]   speed_q, speed_d;
  logic                brake_q, brake_d;
  logic                sol_q, sol_d;
  logic                wake;
  logic [TimeW-1:0]    t_now;
  logic [SpeedW:0]     pwm_sum;

  // Advance the sequencer state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pwm_q     <= '0;
      elapsed_q <= '0;
      speed_q   <= '0;
      brake_q   <= 1'b0;
      sol_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pwm_q     <= pwm_d;
      elapsed_q <= elapsed_d;
      speed_q   <= speed_d;
      brake_q   <= brake_d;
      sol_q     <= sol_d;
    end
  end

  // Saturating millisecond timer, then the up-ramp sum
  assign t_now   = (ms_tick_i && (elapsed_q != TimeMax)) ? elapsed_q + 1'b1 : elapsed_q;
  assign pwm_sum = {1'b0, pwm_q} + {1'b0, cfg_i.accel_step};

  // Next phase and outputs; a phase change restarts the timer
  always_comb begin
    phase_d   = phase_q;
    pwm_d     = pwm_q;
    elapsed_d = t_now;
    speed_d   = speed_q;
    brake_d   = brake_q;
    sol_d     = sol_q;
    wake      = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        speed_d = '0;
        brake_d = 1'b1;
        if (start_pressed_i) begin
          wake      = 1'b1;
          phase_d   = PH_BARK;
          elapsed_d = '0;
        end
      end
      PH_BARK: begin
        brake_d   = 1'b0;
        phase_d   = PH_RUN;
        elapsed_d = '0;
      end
      PH_RUN: begin
        if (pwm_q < cfg_i.pwm_ceil) begin
          pwm_d = (pwm_sum > {1'b0, cfg_i.pwm_ceil}) ? cfg_i.pwm_ceil
                                                      : pwm_sum[SpeedW-1:0];
        end
        speed_d = pwm_d;
        if (t_now > cfg_i.run_time_ms) begin
          phase_d   = PH_DECEL;
          elapsed_d = '0;
        end
      end
      PH_DECEL: begin
        if (pwm_q > cfg_i.pwm_floor) begin
          pwm_d = (pwm_q > cfg_i.decel_step) ? pwm_q - cfg_i.decel_step : '0;
        end else begin
          pwm_d     = cfg_i.pwm_floor;
          phase_d   = PH_SEARCH;
          elapsed_d = '0;
        end
        speed_d = pwm_d;
      end
      PH_SEARCH: begin
        brake_d = 1'b0;
        speed_d = pwm_q;
        if (line_seen_i) begin
          speed_d   = '0;
          brake_d   = 1'b1;
          phase_d   = PH_STOPPED;
          elapsed_d = '0;
        end
      end
      PH_STOPPED: begin
        speed_d   = '0;
        brake_d   = 1'b1;
        phase_d   = PH_KICK;
        elapsed_d = '0;
      end
      PH_KICK: begin
        if (t_now >= cfg_i.kick_delay_ms) begin
          sol_d     = 1'b1;
          phase_d   = PH_END;
          elapsed_d = '0;
        end
      end
      default: begin
        // End phase is final; drop the solenoid after the hold time
        speed_d = '0;
        brake_d = 1'b1;
        if (t_now >= cfg_i.solenoid_hold_ms) begin
          sol_d = 1'b0;
        end
      end
    endcase
  end

  // Result is the state after the update
  always_comb begin
    result_o.motor_speed = speed_d;
    result_o.brake_on    = brake_d;
    result_o.solenoid_on = sol_d;
    result_o.wake_pulse  = wake;
    result_o.phase       = phase_d;
  end

endmodule
`default_nettype wire

@@ design/mrks_out_reg.sv @@
`default_nettype none
module mrks_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mrks_pkg::result_t  result_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mrks_pkg::result_t       result_o
);
  import mrks_pkg::*;

  logic    valid_q;
  result_t data_q;
  logic    load;

  // Take a new transaction when the slot is empty or being emptied
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Hold the valid flag until the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule
`default_nettype wire

@@ design/mrks_checker.sv @@
`default_nettype none
module mrks_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [mrks_pkg::SpeedW-1:0]    motor_speed_o,
  input wire logic                           brake_on_o,
  input wire logic                           wake_pulse_o,
  input wire logic [mrks_pkg::PhaseW-1:0]    phase_o
);
  import mrks_pkg::*;

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before being taken");

  // Stall the input only behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // Wake pulse only on the transaction that leaves idle
  a_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_pulse_o |-> phase_o == PH_BARK)
    else $error("wake pulse outside the bark phase");

  // Motor stopped and braked in idle, stopped and end
  a_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == PH_IDLE || phase_o == PH_STOPPED || phase_o == PH_END)
    |-> brake_on_o && motor_speed_o == '0)
    else $error("motor driven while it should be stopped");

endmodule

bind motor_ramp_kick_sequencer_top mrks_checker u_mrks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .motor_speed_o (motor_speed_o),
  .brake_on_o    (brake_on_o),
  .wake_pulse_o  (wake_pulse_o),
  .phase_o       (phase_o)
);
`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
  import mrks_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxShown   = 10;
  // Register index past the last register; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic start_pressed = 1'b0;
  logic line_seen = 1'b0;
  logic ms_tick = 1'b0;
  logic out_ready = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic in_ready;
  logic out_valid;
  logic [SpeedW-1:0] motor_speed;
  logic brake_on;
  logic solenoid_on;
  logic wake_pulse;
  logic [PhaseW-1:0] phase;

  // Predicted sequencer state and register contents
  cfg_t              mission_cfg;
  phase_e            mission_phase;
  logic [SpeedW-1:0] ramp_pwm;
  logic [TimeW-1:0]  phase_ms;
  logic [SpeedW-1:0] speed_cmd;
  logic              brake_cmd;
  logic              solenoid_cmd;

  // Status transactions still owed by the block, oldest first
  result_t status_q[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  motor_ramp_kick_sequencer_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .start_pressed_i (start_pressed),
    .line_seen_i     (line_seen),
    .ms_tick_i       (ms_tick),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .motor_speed_o   (motor_speed),
    .brake_on_o      (brake_on),
    .solenoid_on_o   (solenoid_on),
    .wake_pulse_o    (wake_pulse),
    .phase_o         (phase),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Change phase and restart the millisecond timer
  function automatic void switch_phase(input phase_e next_phase);
    mission_phase = next_phase;
    phase_ms      = '0;
  endfunction

  // Advance the sequencer by one update and return the status it reports
  function automatic result_t advance_mission(input logic start, input logic line,
                                              input logic tick);
    result_t         res;
    logic            wake;
    logic [SpeedW:0] raised;
    wake = 1'b0;
    if (tick && phase_ms != TimeMax) phase_ms = phase_ms + 1'b1;
    case (mission_phase)
      PH_IDLE: begin
        speed_cmd = '0;
        brake_cmd = 1'b1;
        if (start) begin
          wake = 1'b1;
          switch_phase(PH_BARK);
        end
      end
      PH_BARK: begin
        switch_phase(PH_RUN);
        brake_cmd = 1'b0;
      end
      PH_RUN: begin
        // climb by one step, clamped at the ceiling
        if (ramp_pwm < mission_cfg.pwm_ceil) begin
          raised   = {1'b0, ramp_pwm} + {1'b0, mission_cfg.accel_step};
          ramp_pwm = (raised > {1'b0, mission_cfg.pwm_ceil}) ? mission_cfg.pwm_ceil
                                                             : raised[SpeedW-1:0];
        end
        speed_cmd = ramp_pwm;
        if (phase_ms > mission_cfg.run_time_ms) switch_phase(PH_DECEL);
      end
      PH_DECEL: begin
        // descend by one step, saturating at zero, until the floor is reached
        if (ramp_pwm > mission_cfg.pwm_floor) begin
          ramp_pwm = (ramp_pwm > mission_cfg.decel_step) ?
                     ramp_pwm - mission_cfg.decel_step : '0;
          speed_cmd = ramp_pwm;
        end else begin
          ramp_pwm  = mission_cfg.pwm_floor;
          speed_cmd = ramp_pwm;
          switch_phase(PH_SEARCH);
        end
      end
      PH_SEARCH: begin
        brake_cmd = 1'b0;
        speed_cmd = ramp_pwm;
        if (line) begin
          speed_cmd = '0;
          brake_cmd = 1'b1;
          switch_phase(PH_STOPPED);
        end
      end
      PH_STOPPED: begin
        speed_cmd = '0;
        brake_cmd = 1'b1;
        switch_phase(PH_KICK);
      end
      PH_KICK: begin
        if (phase_ms >= mission_cfg.kick_delay_ms) begin
          solenoid_cmd = 1'b1;
          switch_phase(PH_END);
        end
      end
      default: begin
        speed_cmd = '0;
        brake_cmd = 1'b1;
        if (phase_ms >= mission_cfg.solenoid_hold_ms) solenoid_cmd = 1'b0;
      end
    endcase
    res.motor_speed = speed_cmd;
    res.brake_on    = brake_cmd;
    res.solenoid_on = solenoid_cmd;
    res.wake_pulse  = wake;
    res.phase       = mission_phase;
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // Offer one update, optionally after an idle burst, and record its status
  task automatic send_item(input logic start, input logic line, input logic tick);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    start_pressed <= start;
    line_seen     <= line;
    ms_tick       <= tick;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(advance_mission(start, line, tick));
  endtask

  // Drop valid and wait for every owed status to arrive
  task automatic settle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register; only called while nothing is in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PWM_CEIL:   mission_cfg.pwm_ceil         = value[SpeedW-1:0];
      CFG_PWM_FLOOR:  mission_cfg.pwm_floor        = value[SpeedW-1:0];
      CFG_ACCEL_STEP: mission_cfg.accel_step       = value[SpeedW-1:0];
      CFG_DECEL_STEP: mission_cfg.decel_step       = value[SpeedW-1:0];
      CFG_RUN_TIME:   mission_cfg.run_time_ms      = value;
      CFG_KICK_DELAY: mission_cfg.kick_delay_ms    = value;
      CFG_SOL_HOLD:   mission_cfg.solenoid_hold_ms = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Feed random updates while the sequencer stays in one phase; odds are 1 in n
  task automatic drive_phase(input phase_e ph, input int unsigned cap,
                             input int unsigned line_odds, input int unsigned tick_odds);
    int unsigned n;
    n = 0;
    while (mission_phase == ph && n < cap) begin
      send_item(ph != PH_IDLE && $urandom_range(0, 1) == 1,
                $urandom_range(0, line_odds - 1) == 0,
                $urandom_range(0, tick_odds - 1) == 0);
      n++;
    end
  endtask

  task automatic test_idle_hold();
    // line and tick alone must not wake the sequencer
    send_item(1'b0, 1'b0, 1'b0);
    send_item(1'b0, 1'b1, 1'b1);
    send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b0, 1'b0, 1'b1);
    settle();
    // push every register to an extreme; upper data bits must be dropped
    write_reg(CFG_PWM_CEIL, {8'($urandom), 8'd0});
    write_reg(CFG_PWM_FLOOR, {8'($urandom), 8'd255});
    write_reg(CFG_ACCEL_STEP, {8'($urandom), 8'd255});
    write_reg(CFG_DECEL_STEP, {8'($urandom), 8'd255});
    write_reg(CFG_RUN_TIME, 16'd0);
    write_reg(CFG_KICK_DELAY, 16'd0);
    write_reg(CFG_SOL_HOLD, 16'd0);
    write_reg(CfgIdxSpare, 16'($urandom));
    drive_phase(PH_IDLE, 100, 2, 2);
    settle();
  endtask

  task automatic test_wake_pulse();
    write_reg(CFG_ACCEL_STEP, {8'($urandom), 8'd0});
    write_reg(CFG_PWM_CEIL, 16'd90);
    write_reg(CFG_RUN_TIME, 16'hFFFF);
    send_item(1'b1, 1'b1, 1'b1);
    // start is ignored once out of idle
    send_item(1'b1, 1'b0, 1'b1);
    // zero step keeps the PWM at zero
    drive_phase(PH_RUN, 6, 2, 2);
    settle();
  endtask

  task automatic test_up_ramp();
    write_reg(CFG_ACCEL_STEP, {8'($urandom), 8'd37});
    write_reg(CFG_PWM_CEIL, 16'd100);
    drive_phase(PH_RUN, 60, 2, 2);
    settle();
    // sum past 255 must clamp at the ceiling
    write_reg(CFG_PWM_CEIL, 16'd255);
    write_reg(CFG_ACCEL_STEP, 16'd255);
    drive_phase(PH_RUN, 20, 2, 2);
    settle();
    // ceiling below the level: hold the level
    write_reg(CFG_PWM_CEIL, {8'($urandom), 8'd0});
    drive_phase(PH_RUN, 60, 2, 2);
    settle();
  endtask

  task automatic test_run_timeout();
    // tick on every update, back to back; the longest run time never ends run
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    drive_phase(PH_RUN, 20, 2, 1);
    settle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    // one below the elapsed time is exceeded without a further tick
    write_reg(CFG_RUN_TIME, phase_ms - 16'd1);
    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    settle();
  endtask

  task automatic test_down_ramp();
    write_reg(CFG_DECEL_STEP, {8'($urandom), 8'd0});
    write_reg(CFG_PWM_FLOOR, 16'd0);
    drive_phase(PH_DECEL, 30, 2, 2);
    settle();
    write_reg(CFG_DECEL_STEP, 16'd100);
    drive_phase(PH_DECEL, 2, 2, 2);
    settle();
    // step larger than the level saturates at zero, then snap up to the floor
    write_reg(CFG_PWM_FLOOR, 16'd40);
    write_reg(CFG_DECEL_STEP, 16'd200);
    drive_phase(PH_DECEL, 10, 2, 2);
    settle();
  endtask

  task automatic test_line_search();
    write_reg(CFG_KICK_DELAY, 16'hFFFF);
    write_reg(CFG_RUN_TIME, 16'($urandom));
    drive_phase(PH_SEARCH, 300, 25, 2);
    if (mission_phase == PH_SEARCH) send_item(1'b0, 1'b1, 1'b1);
    drive_phase(PH_STOPPED, 1, 2, 2);
    settle();
  endtask

  task automatic test_kick();
    write_reg(CFG_SOL_HOLD, 16'hFFFF);
    drive_phase(PH_KICK, 80, 2, 2);
    settle();
    write_reg(CFG_KICK_DELAY, phase_ms + 16'd5);
    drive_phase(PH_KICK, 200, 2, 2);
    settle();
  endtask

  task automatic test_end_hold();
    drive_phase(PH_END, 60, 2, 2);
    settle();
    write_reg(CFG_SOL_HOLD, phase_ms + 16'($urandom_range(4, 12)));
    drive_phase(PH_END, 40, 2, 2);
    settle();
    // end is final whatever the registers say
    write_reg(CFG_SOL_HOLD, 16'd0);
    write_reg(CFG_PWM_CEIL, 16'($urandom));
    write_reg(CFG_PWM_FLOOR, 16'($urandom));
    write_reg(CFG_KICK_DELAY, 16'($urandom));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    drive_phase(PH_END, 60, 2, 2);
  endtask

  // Check each status transaction against the oldest prediction; apply back-pressure
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          log_mismatch($sformatf("unexpected transaction, phase %0d speed %0d",
                                 phase, motor_speed));
        end else begin
          want = status_q.pop_front();
          if (motor_speed !== want.motor_speed)
            log_mismatch($sformatf("motor_speed expected %0d, got %0d",
                                   want.motor_speed, motor_speed));
          if (brake_on !== want.brake_on)
            log_mismatch($sformatf("brake_on expected %0b, got %0b", want.brake_on, brake_on));
          if (solenoid_on !== want.solenoid_on)
            log_mismatch($sformatf("solenoid_on expected %0b, got %0b",
                                   want.solenoid_on, solenoid_on));
          if (wake_pulse !== want.wake_pulse)
            log_mismatch($sformatf("wake_pulse expected %0b, got %0b",
                                   want.wake_pulse, wake_pulse));
          if (phase !== want.phase)
            log_mismatch($sformatf("phase expected %0d, got %0d", want.phase, phase));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0) out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    // registers and sequencer as they come out of reset
    mission_cfg.pwm_ceil         = SpeedMaxRst;
    mission_cfg.pwm_floor        = SpeedMinRst;
    mission_cfg.accel_step       = AccelStepRst;
    mission_cfg.decel_step       = DecelStepRst;
    mission_cfg.run_time_ms      = RunTimeRst;
    mission_cfg.kick_delay_ms    = KickDelayRst;
    mission_cfg.solenoid_hold_ms = SolHoldRst;
    mission_phase = PH_IDLE;
    ramp_pwm      = '0;
    phase_ms      = '0;
    speed_cmd     = '0;
    brake_cmd     = 1'b0;
    solenoid_cmd  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_hold();
    test_wake_pulse();
    test_up_ramp();
    test_run_timeout();
    test_down_ramp();
    test_line_search();
    test_kick();
    test_end_hold();

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
